// File: rtl/core/halfblock_pixel_color_quantizer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the half-block pixel color quantizer
// Shared concurrent-check forms, clocked on the rising edge and held off
// while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef HALFBLOCK_PIXEL_COLOR_QUANTIZER_UNIT_DEFINES_SVH
`define HALFBLOCK_PIXEL_COLOR_QUANTIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define HBQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hbq same-cycle check failed");

// next-cycle implication
`define HBQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hbq next-cycle check failed");

`endif

// File: rtl/core/hbq_pkg.sv
// ---------------------------------------------------------------------------
// hbq_pkg
// Types, register indexes, mode codes and constant tables shared by the
// half-block pixel color quantizer.
// ---------------------------------------------------------------------------
package hbq_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hbq_rgb_t;

  // per-stage load enables, driven by the top-level flow control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } hbq_adv_t;

  typedef struct packed {
    logic     alpha_en;
    hbq_rgb_t backdrop;
  } hbq_cfg_t;

  // configuration register indexes
  localparam logic [2:0] CFG_DISPLAY_MODE   = 3'd0;
  localparam logic [2:0] CFG_ALPHA_ENABLE   = 3'd1;
  localparam logic [2:0] CFG_BACKDROP_RED   = 3'd2;
  localparam logic [2:0] CFG_BACKDROP_GREEN = 3'd3;
  localparam logic [2:0] CFG_BACKDROP_BLUE  = 3'd4;

  // display modes
  localparam logic [1:0] MODE_TRUECOLOR = 2'd0;
  localparam logic [1:0] MODE_PALETTE   = 2'd1;
  localparam logic [1:0] MODE_ASCII     = 2'd2;

  localparam logic [7:0] BACKDROP_RESET = 8'd128;

  // palette constants
  localparam logic [7:0] GREY_DEV_MAX  = 8'd12;
  localparam logic [7:0] GREY_LOW      = 8'd8;
  localparam logic [7:0] GREY_HIGH     = 8'd238;
  localparam logic [7:0] PAL_BLACK     = 8'd16;
  localparam logic [7:0] PAL_WHITE     = 8'd231;
  localparam logic [7:0] PAL_GREY_BASE = 8'd232;
  localparam logic [7:0] PAL_CUBE_BASE = 8'd16;

  // channel value at which the rounded 0..5 cube level steps up
  localparam int unsigned CUBE_STEPS = 5;
  localparam logic [7:0] CUBE_STEP [CUBE_STEPS] = '{8'd26, 8'd77, 8'd128, 8'd179, 8'd230};

  // weighted luma sum (299r + 587g + 114b) at which the ramp position steps up
  localparam int unsigned RAMP_LEN = 10;
  localparam logic [17:0] LUMA_STEP [RAMP_LEN-1] = '{
    18'd29000, 18'd57000, 18'd85000, 18'd114000, 18'd142000,
    18'd170000, 18'd199000, 18'd227000, 18'd255000
  };

  // " .:-=+*#%@"
  localparam logic [6:0] RAMP_CHAR [RAMP_LEN] = '{
    7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
  };

endpackage

// File: rtl/core/hbq_lane.sv
// ---------------------------------------------------------------------------
// hbq_lane
// One pixel lane: alpha compositing over the backdrop when enabled, then
// mapping of the composited color to an xterm 256 palette index.
// ---------------------------------------------------------------------------
module hbq_lane (
  input  logic              clk,
  input  hbq_pkg::hbq_adv_t adv,
  input  hbq_pkg::hbq_cfg_t cfg,
  input  hbq_pkg::hbq_rgb_t pix,
  input  logic [7:0]        pix_alpha,
  output hbq_pkg::hbq_rgb_t color_s2,
  output logic [7:0]        palette
);

  logic [7:0]  pix_ch   [3];
  logic [7:0]  bg_ch    [3];
  logic [15:0] blend_nxt [3];
  logic [15:0] blend_r  [3];
  logic [7:0]  raw_r    [3];
  logic [7:0]  comp_nxt [3];
  logic [7:0]  comp_r   [3];
  logic [9:0]  chan_sum;
  logic [18:0] mean_prod;
  logic [7:0]  mean_nxt;
  logic [7:0]  mean_r;
  logic [2:0]  lvl_nxt  [3];
  logic [2:0]  lvl_r    [3];
  logic [7:0]  col3_r   [3];
  logic [2:0]  dev_ok;
  logic [7:0]  dev      [3];
  logic [7:0]  grey_off;
  logic [15:0] grey_prod;
  logic [7:0]  grey_idx;
  logic [7:0]  cube_idx;

  assign pix_ch[0] = pix.red;
  assign pix_ch[1] = pix.green;
  assign pix_ch[2] = pix.blue;
  assign bg_ch[0]  = cfg.backdrop.red;
  assign bg_ch[1]  = cfg.backdrop.green;
  assign bg_ch[2]  = cfg.backdrop.blue;

  // stage 1: a*c + (255-a)*bg + 127
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      blend_nxt[i] = 16'(pix_alpha) * 16'(pix_ch[i])
                   + 16'(8'd255 - pix_alpha) * 16'(bg_ch[i]) + 16'd127;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int i = 0; i < 3; i++) begin
        blend_r[i] <= blend_nxt[i];
        raw_r[i]   <= pix_ch[i];
      end
    end
  end

  // stage 2: divide by 255 as (y + (y >> 8)) >> 8 with y = x + 1
  always_comb begin
    logic [15:0] y;
    logic [15:0] q;
    for (int i = 0; i < 3; i++) begin
      y           = blend_r[i] + 16'd1;
      q           = (y + (y >> 8)) >> 8;
      comp_nxt[i] = cfg.alpha_en ? q[7:0] : raw_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int i = 0; i < 3; i++) begin
        comp_r[i] <= comp_nxt[i];
      end
    end
  end

  assign color_s2.red   = comp_r[0];
  assign color_s2.green = comp_r[1];
  assign color_s2.blue  = comp_r[2];

  // stage 3: channel mean (sum * 683 >> 11 is exact /3 here) and cube levels
  assign chan_sum  = 10'(comp_r[0]) + 10'(comp_r[1]) + 10'(comp_r[2]);
  assign mean_prod = 19'(chan_sum) * 19'd683;
  assign mean_nxt  = mean_prod[18:11];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvl_nxt[i] = 3'd0;
      for (int j = 0; j < hbq_pkg::CUBE_STEPS; j++) begin
        lvl_nxt[i] = lvl_nxt[i] + 3'(comp_r[i] >= hbq_pkg::CUBE_STEP[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      mean_r <= mean_nxt;
      for (int i = 0; i < 3; i++) begin
        lvl_r[i]  <= lvl_nxt[i];
        col3_r[i] <= comp_r[i];
      end
    end
  end

  // grey ramp versus color cube
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dev[i]    = (col3_r[i] >= mean_r) ? (col3_r[i] - mean_r) : (mean_r - col3_r[i]);
      dev_ok[i] = (dev[i] <= hbq_pkg::GREY_DEV_MAX);
    end
  end

  // (mean - 8) / 10 as a multiply by 205 >> 11
  assign grey_off  = mean_r - hbq_pkg::GREY_LOW;
  assign grey_prod = 16'(grey_off) * 16'd205;

  always_comb begin
    if (mean_r < hbq_pkg::GREY_LOW) begin
      grey_idx = hbq_pkg::PAL_BLACK;
    end else if (mean_r > hbq_pkg::GREY_HIGH) begin
      grey_idx = hbq_pkg::PAL_WHITE;
    end else begin
      grey_idx = hbq_pkg::PAL_GREY_BASE + 8'(grey_prod[15:11]);
    end
  end

  assign cube_idx = hbq_pkg::PAL_CUBE_BASE + 8'd36 * 8'(lvl_r[0])
                  + 8'd6 * 8'(lvl_r[1]) + 8'(lvl_r[2]);

  assign palette = (&dev_ok) ? grey_idx : cube_idx;

endmodule

// File: rtl/core/hbq_merge.sv
// ---------------------------------------------------------------------------
// hbq_merge
// Combines the two lanes: averages them for the ascii luminance ramp and
// selects the result fields of the current display mode into the output
// register.
// ---------------------------------------------------------------------------
module hbq_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  hbq_pkg::hbq_adv_t adv,
  input  logic [1:0]        display_mode,
  input  hbq_pkg::hbq_rgb_t top_color,
  input  hbq_pkg::hbq_rgb_t low_color,
  input  logic [7:0]        top_palette,
  input  logic [7:0]        low_palette,
  output hbq_pkg::hbq_rgb_t fore_color,
  output hbq_pkg::hbq_rgb_t back_color,
  output logic [7:0]        fore_palette,
  output logic [7:0]        back_palette,
  output logic [6:0]        ramp_char
);

  logic [8:0]        sum_red;
  logic [8:0]        sum_green;
  logic [8:0]        sum_blue;
  logic [17:0]       luma_nxt;
  logic [17:0]       luma_r;
  hbq_pkg::hbq_rgb_t top3_r;
  hbq_pkg::hbq_rgb_t low3_r;
  logic [3:0]        ramp_pos;
  hbq_pkg::hbq_rgb_t fore_r;
  hbq_pkg::hbq_rgb_t back_r;
  logic [7:0]        fore_pal_r;
  logic [7:0]        back_pal_r;
  logic [6:0]        ramp_char_r;

  // stage 3: per-channel average of both pixels, weighted luma sum
  assign sum_red   = 9'(top_color.red)   + 9'(low_color.red);
  assign sum_green = 9'(top_color.green) + 9'(low_color.green);
  assign sum_blue  = 9'(top_color.blue)  + 9'(low_color.blue);
  assign luma_nxt  = 18'd299 * 18'(sum_red[8:1]) + 18'd587 * 18'(sum_green[8:1])
                   + 18'd114 * 18'(sum_blue[8:1]);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      luma_r <= luma_nxt;
      top3_r <= top_color;
      low3_r <= low_color;
    end
  end

  // ramp position counts the luma steps passed
  always_comb begin
    ramp_pos = 4'd0;
    for (int k = 0; k < hbq_pkg::RAMP_LEN - 1; k++) begin
      ramp_pos = ramp_pos + 4'(luma_r >= hbq_pkg::LUMA_STEP[k]);
    end
  end

  // stage 4: output register, unused fields zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r      <= '0;
      back_r      <= '0;
      fore_pal_r  <= '0;
      back_pal_r  <= '0;
      ramp_char_r <= '0;
    end else if (adv.s4) begin
      fore_r      <= '0;
      back_r      <= '0;
      fore_pal_r  <= '0;
      back_pal_r  <= '0;
      ramp_char_r <= '0;
      case (display_mode)
        hbq_pkg::MODE_TRUECOLOR: begin
          fore_r <= top3_r;
          back_r <= low3_r;
        end
        hbq_pkg::MODE_PALETTE: begin
          fore_pal_r <= top_palette;
          back_pal_r <= low_palette;
        end
        hbq_pkg::MODE_ASCII: begin
          ramp_char_r <= hbq_pkg::RAMP_CHAR[ramp_pos];
        end
        default: begin
        end
      endcase
    end
  end

  assign fore_color   = fore_r;
  assign back_color   = back_r;
  assign fore_palette = fore_pal_r;
  assign back_palette = back_pal_r;
  assign ramp_char    = ramp_char_r;

endmodule

// File: rtl/core/halfblock_pixel_color_quantizer_unit.sv
// ---------------------------------------------------------------------------
// halfblock_pixel_color_quantizer_unit
// Quantizes one half-block cell (upper and lower RGBA pixel) per transfer
// into truecolor, xterm 256 palette indices or an ascii ramp character.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one cell per transfer (in_valid high, in_stall low).
//   Result channel out_*: one result per cell, in order; fields the current
//   display mode does not use are zero.
//   Config channel cfg_*: cfg_ready is always high; index 0 display mode,
//   1 alpha enable, 2..4 backdrop red/green/blue. Write only while idle.
//   Indexes beyond 4 are ignored.
// Timing:
//   One cell per cycle sustained while out_stall stays low: the two pixel
//   lanes and the merge stage form a four-stage pipeline (product, divide
//   by 255, mean/luma, select); out_valid rises when a cell loads the
//   output register of the select stage.
// Reset:
//   Synchronous, active low; clears all stage valids and sets mode 0,
//   alpha off and a backdrop of 128 on every channel.
// Stall:
//   Each stage holds while its successor is full and not moving; bubbles
//   close up, so input is taken while the output register waits.
// ---------------------------------------------------------------------------
`include "halfblock_pixel_color_quantizer_unit_defines.svh"

module halfblock_pixel_color_quantizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_top_red,
  input  logic [7:0] in_top_green,
  input  logic [7:0] in_top_blue,
  input  logic [7:0] in_top_alpha,
  input  logic [7:0] in_low_red,
  input  logic [7:0] in_low_green,
  input  logic [7:0] in_low_blue,
  input  logic [7:0] in_low_alpha,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_fore_red,
  output logic [7:0] out_fore_green,
  output logic [7:0] out_fore_blue,
  output logic [7:0] out_back_red,
  output logic [7:0] out_back_green,
  output logic [7:0] out_back_blue,
  output logic [7:0] out_fore_palette,
  output logic [7:0] out_back_palette,
  output logic [6:0] out_ramp_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [1:0]        display_mode_r;
  hbq_pkg::hbq_cfg_t cfg_r;
  logic              s1_valid_r;
  logic              s2_valid_r;
  logic              s3_valid_r;
  logic              out_valid_r;
  logic              rdy1;
  logic              rdy2;
  logic              rdy3;
  logic              rdy4;
  hbq_pkg::hbq_adv_t adv;
  hbq_pkg::hbq_rgb_t top_pix;
  hbq_pkg::hbq_rgb_t low_pix;
  hbq_pkg::hbq_rgb_t top_color;
  hbq_pkg::hbq_rgb_t low_color;
  logic [7:0]        top_palette;
  logic [7:0]        low_palette;
  hbq_pkg::hbq_rgb_t fore_color;
  hbq_pkg::hbq_rgb_t back_color;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r       <= hbq_pkg::MODE_TRUECOLOR;
      cfg_r.alpha_en       <= 1'b0;
      cfg_r.backdrop.red   <= hbq_pkg::BACKDROP_RESET;
      cfg_r.backdrop.green <= hbq_pkg::BACKDROP_RESET;
      cfg_r.backdrop.blue  <= hbq_pkg::BACKDROP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbq_pkg::CFG_DISPLAY_MODE:   display_mode_r       <= cfg_data[1:0];
        hbq_pkg::CFG_ALPHA_ENABLE:   cfg_r.alpha_en       <= cfg_data[0];
        hbq_pkg::CFG_BACKDROP_RED:   cfg_r.backdrop.red   <= cfg_data;
        hbq_pkg::CFG_BACKDROP_GREEN: cfg_r.backdrop.green <= cfg_data;
        hbq_pkg::CFG_BACKDROP_BLUE:  cfg_r.backdrop.blue  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a stage may load when it is empty or its contents move on
  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  assign adv.s1 = in_valid && rdy1;
  assign adv.s2 = s1_valid_r && rdy2;
  assign adv.s3 = s2_valid_r && rdy3;
  assign adv.s4 = s3_valid_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_valid;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (rdy4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  assign top_pix.red   = in_top_red;
  assign top_pix.green = in_top_green;
  assign top_pix.blue  = in_top_blue;
  assign low_pix.red   = in_low_red;
  assign low_pix.green = in_low_green;
  assign low_pix.blue  = in_low_blue;

  hbq_lane u_lane_top (
    .clk       (clk),
    .adv       (adv),
    .cfg       (cfg_r),
    .pix       (top_pix),
    .pix_alpha (in_top_alpha),
    .color_s2  (top_color),
    .palette   (top_palette)
  );

  hbq_lane u_lane_low (
    .clk       (clk),
    .adv       (adv),
    .cfg       (cfg_r),
    .pix       (low_pix),
    .pix_alpha (in_low_alpha),
    .color_s2  (low_color),
    .palette   (low_palette)
  );

  hbq_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .display_mode (display_mode_r),
    .top_color    (top_color),
    .low_color    (low_color),
    .top_palette  (top_palette),
    .low_palette  (low_palette),
    .fore_color   (fore_color),
    .back_color   (back_color),
    .fore_palette (out_fore_palette),
    .back_palette (out_back_palette),
    .ramp_char    (out_ramp_char)
  );

  assign out_valid      = out_valid_r;
  assign out_fore_red   = fore_color.red;
  assign out_fore_green = fore_color.green;
  assign out_fore_blue  = fore_color.blue;
  assign out_back_red   = back_color.red;
  assign out_back_green = back_color.green;
  assign out_back_blue  = back_color.blue;

  // full pipeline behind a stalled output must push back on the input
  `HBQ_ASSERT_IMPLY(a_full_stall, clk, rst_n,
    out_valid_r && out_stall && s3_valid_r && s2_valid_r && s1_valid_r, in_stall)
  // an ascii result never carries palette fields
  `HBQ_ASSERT_IMPLY(a_mode_excl, clk, rst_n,
    out_ramp_char != 7'd0, out_fore_palette == 8'd0 && out_back_palette == 8'd0)
  // palette indexes never fall into the 16 system colors
  `HBQ_ASSERT_IMPLY(a_pal_range, clk, rst_n,
    out_fore_palette != 8'd0, out_fore_palette >= hbq_pkg::PAL_BLACK)
  // an item in the last stage reaches the output when it is free
  `HBQ_ASSERT_NEXT(a_drain, clk, rst_n, s3_valid_r && rdy4, out_valid_r)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Half-block pixel color quantizer testbench
// Drives RGBA cells through the unit under several register settings
// (truecolor, palette, ascii, the unused mode, alpha on and off, extreme and
// random backdrops), predicts every result and checks it against the output
// channel. Both channels idle at random, and one long receiver hold-off
// makes the pipeline fill up and stall its input.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         PIPE_DEPTH   = 4;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         RAND_PHASES  = 8;
  localparam int         PHASE_CELLS  = 60;
  localparam int         IDLE_PCT     = 21;

  typedef struct packed {
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] top_alpha;
    logic [7:0] low_red;
    logic [7:0] low_green;
    logic [7:0] low_blue;
    logic [7:0] low_alpha;
  } cell_t;

  typedef struct packed {
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
    logic [7:0] fore_palette;
    logic [7:0] back_palette;
    logic [6:0] ramp_char;
  } quant_t;

  class cell_scoreboard;
    quant_t     pending[$];
    logic [1:0] mode;
    logic       alpha_on;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    int         errors;
    int         cells;
    int         results;
    logic [3:0] modes_seen;

    function new();
      mode       = hbq_pkg::MODE_TRUECOLOR;
      alpha_on   = 1'b0;
      bg_red     = 8'd128;
      bg_green   = 8'd128;
      bg_blue    = 8'd128;
      errors     = 0;
      cells      = 0;
      results    = 0;
      modes_seen = '0;
    endfunction

    function void set_register(logic [2:0] idx, logic [7:0] data);
      case (idx)
        hbq_pkg::CFG_DISPLAY_MODE:   mode     = data[1:0];
        hbq_pkg::CFG_ALPHA_ENABLE:   alpha_on = data[0];
        hbq_pkg::CFG_BACKDROP_RED:   bg_red   = data;
        hbq_pkg::CFG_BACKDROP_GREEN: bg_green = data;
        hbq_pkg::CFG_BACKDROP_BLUE:  bg_blue  = data;
        default: ;
      endcase
    endfunction

    function int unsigned over_backdrop(int unsigned c, int unsigned a, int unsigned bg);
      if (!alpha_on) return c;
      return (a * c + (255 - a) * bg + 127) / 255;
    endfunction

    function int unsigned spread(int unsigned c, int unsigned mean);
      return (c > mean) ? c - mean : mean - c;
    endfunction

    function logic [7:0] xterm_index(int unsigned r, int unsigned g, int unsigned b);
      int unsigned mean;
      mean = (r + g + b) / 3;
      if (spread(r, mean) <= 12 && spread(g, mean) <= 12 && spread(b, mean) <= 12) begin
        if (mean < 8) return 8'd16;
        if (mean > 238) return 8'd231;
        return 8'(232 + (mean - 8) * 24 / 240);
      end
      return 8'(16 + 36 * ((r * 5 + 127) / 255) + 6 * ((g * 5 + 127) / 255)
                + (b * 5 + 127) / 255);
    endfunction

    function logic [6:0] luma_glyph(int unsigned r, int unsigned g, int unsigned b);
      string       glyphs = " .:-=+*#%@";
      int unsigned luma;
      int unsigned pos;
      luma = (299 * r + 587 * g + 114 * b) / 1000;
      pos  = luma * 9 / 255;
      if (pos > 9) pos = 9;
      return 7'(glyphs[pos]);
    endfunction

    function quant_t quantize(cell_t c);
      quant_t      q;
      int unsigned tr, tg, tb, lr, lg, lb;
      tr = over_backdrop(c.top_red,   c.top_alpha, bg_red);
      tg = over_backdrop(c.top_green, c.top_alpha, bg_green);
      tb = over_backdrop(c.top_blue,  c.top_alpha, bg_blue);
      lr = over_backdrop(c.low_red,   c.low_alpha, bg_red);
      lg = over_backdrop(c.low_green, c.low_alpha, bg_green);
      lb = over_backdrop(c.low_blue,  c.low_alpha, bg_blue);
      q = '0;
      case (mode)
        hbq_pkg::MODE_TRUECOLOR: begin
          q.fore_red   = 8'(tr);
          q.fore_green = 8'(tg);
          q.fore_blue  = 8'(tb);
          q.back_red   = 8'(lr);
          q.back_green = 8'(lg);
          q.back_blue  = 8'(lb);
        end
        hbq_pkg::MODE_PALETTE: begin
          q.fore_palette = xterm_index(tr, tg, tb);
          q.back_palette = xterm_index(lr, lg, lb);
        end
        hbq_pkg::MODE_ASCII: begin
          q.ramp_char = luma_glyph((tr + lr) / 2, (tg + lg) / 2, (tb + lb) / 2);
        end
        default: ;
      endcase
      return q;
    endfunction

    function void note_cell(cell_t c);
      pending.push_back(quantize(c));
      cells++;
      modes_seen[mode] = 1'b1;
    endfunction

    function void check_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      end
    endfunction

    function void check_result(quant_t got);
      quant_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no cell pending: expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      results++;
      check_field("fore_red",     want.fore_red,     got.fore_red);
      check_field("fore_green",   want.fore_green,   got.fore_green);
      check_field("fore_blue",    want.fore_blue,    got.fore_blue);
      check_field("back_red",     want.back_red,     got.back_red);
      check_field("back_green",   want.back_green,   got.back_green);
      check_field("back_blue",    want.back_blue,    got.back_blue);
      check_field("fore_palette", want.fore_palette, got.fore_palette);
      check_field("back_palette", want.back_palette, got.back_palette);
      check_field("ramp_char",    want.ramp_char,    got.ramp_char);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_top_red;
  logic [7:0] in_top_green;
  logic [7:0] in_top_blue;
  logic [7:0] in_top_alpha;
  logic [7:0] in_low_red;
  logic [7:0] in_low_green;
  logic [7:0] in_low_blue;
  logic [7:0] in_low_alpha;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_fore_red;
  logic [7:0] out_fore_green;
  logic [7:0] out_fore_blue;
  logic [7:0] out_back_red;
  logic [7:0] out_back_green;
  logic [7:0] out_back_blue;
  logic [7:0] out_fore_palette;
  logic [7:0] out_back_palette;
  logic [6:0] out_ramp_char;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  cell_scoreboard quant;
  bit             tx_gaps;
  bit             rx_gaps;
  int             hold_cycles;
  int             cycle_count;
  int             settings;

  halfblock_pixel_color_quantizer_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_top_red       (in_top_red),
    .in_top_green     (in_top_green),
    .in_top_blue      (in_top_blue),
    .in_top_alpha     (in_top_alpha),
    .in_low_red       (in_low_red),
    .in_low_green     (in_low_green),
    .in_low_blue      (in_low_blue),
    .in_low_alpha     (in_low_alpha),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fore_red     (out_fore_red),
    .out_fore_green   (out_fore_green),
    .out_fore_blue    (out_fore_blue),
    .out_back_red     (out_back_red),
    .out_back_green   (out_back_green),
    .out_back_blue    (out_back_blue),
    .out_fore_palette (out_fore_palette),
    .out_back_palette (out_back_palette),
    .out_ramp_char    (out_ramp_char),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** halfblock_pixel_color_quantizer_unit: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, plus a counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   = 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall = rx_gaps && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      quant.check_result('{out_fore_red, out_fore_green, out_fore_blue,
                           out_back_red, out_back_green, out_back_blue,
                           out_fore_palette, out_back_palette, out_ramp_char});
  end

  function automatic cell_t mk_cell(int tr, int tg, int tb, int ta,
                                    int lr, int lg, int lb, int la);
    return '{8'(tr), 8'(tg), 8'(tb), 8'(ta), 8'(lr), 8'(lg), 8'(lb), 8'(la)};
  endfunction

  function automatic logic [7:0] near_grey(int base);
    int v;
    v = base + int'($urandom_range(0, 30)) - 15;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int    kind;
    int    base;
    c    = cell_t'({$urandom, $urandom});
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    if (kind >= 5 && kind <= 7) begin
      // hover around the grey/cube boundary
      c.top_red   = near_grey(base);
      c.top_green = near_grey(base);
      c.top_blue  = near_grey(base);
      base        = $urandom_range(0, 255);
      c.low_red   = near_grey(base);
      c.low_green = near_grey(base);
      c.low_blue  = near_grey(base);
    end else if (kind == 8) begin
      c.top_alpha = {8{$urandom_range(0, 1) == 1}};
      c.low_alpha = {8{$urandom_range(0, 1) == 1}};
    end else if (kind == 9) begin
      c.top_red   = {8{$urandom_range(0, 1) == 1}};
      c.top_green = {8{$urandom_range(0, 1) == 1}};
      c.top_blue  = {8{$urandom_range(0, 1) == 1}};
      c.low_red   = {8{$urandom_range(0, 1) == 1}};
      c.low_green = {8{$urandom_range(0, 1) == 1}};
      c.low_blue  = {8{$urandom_range(0, 1) == 1}};
    end
    return c;
  endfunction

  task automatic drive_cell(cell_t c);
    @(negedge clk);
    while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_top_red   = c.top_red;
    in_top_green = c.top_green;
    in_top_blue  = c.top_blue;
    in_top_alpha = c.top_alpha;
    in_low_red   = c.low_red;
    in_low_green = c.low_green;
    in_low_blue  = c.low_blue;
    in_low_alpha = c.low_alpha;
    do @(posedge clk); while (in_stall);
    quant.note_cell(c);
  endtask

  // drop valid, let every pending result out, then let the pipeline empty
  task automatic drain_cells();
    @(negedge clk);
    in_valid = 1'b0;
    while (quant.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    quant.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // junk in the upper bits of the narrow registers must be dropped
  task automatic set_phase(logic [1:0] mode, logic alpha, int br, int bgr, int bb);
    logic [7:0] d;
    drain_cells();
    d      = 8'($urandom);
    d[1:0] = mode;
    write_reg(hbq_pkg::CFG_DISPLAY_MODE, d);
    d      = 8'($urandom);
    d[0]   = alpha;
    write_reg(hbq_pkg::CFG_ALPHA_ENABLE, d);
    write_reg(hbq_pkg::CFG_BACKDROP_RED, 8'(br));
    write_reg(hbq_pkg::CFG_BACKDROP_GREEN, 8'(bgr));
    write_reg(hbq_pkg::CFG_BACKDROP_BLUE, 8'(bb));
    write_reg(3'($urandom_range(5, 7)), 8'($urandom));
    settings++;
  endtask

  initial begin
    quant        = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_top_red   = '0;
    in_top_green = '0;
    in_top_blue  = '0;
    in_top_alpha = '0;
    in_low_red   = '0;
    in_low_green = '0;
    in_low_blue  = '0;
    in_low_alpha = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_cycles  = 0;
    cycle_count  = 0;
    settings     = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: truecolor, no alpha
    drive_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0));
    drive_cell(mk_cell(255, 255, 255, 255, 255, 255, 255, 255));
    drive_cell(mk_cell(8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55, 8'hAA));

    // alpha extremes over an extreme backdrop
    set_phase(hbq_pkg::MODE_TRUECOLOR, 1'b1, 0, 255, 0);
    drive_cell(mk_cell(200, 100, 50, 0, 10, 20, 30, 255));
    drive_cell(mk_cell(255, 255, 255, 128, 0, 0, 0, 1));

    // grey ramp ends, deviation limit, cube
    set_phase(hbq_pkg::MODE_PALETTE, 1'b0, 128, 128, 128);
    drive_cell(mk_cell(5, 5, 5, 0, 250, 250, 250, 0));
    drive_cell(mk_cell(239, 239, 239, 0, 238, 238, 238, 0));
    drive_cell(mk_cell(8, 8, 8, 0, 100, 112, 88, 0));
    drive_cell(mk_cell(100, 113, 87, 0, 255, 0, 0, 0));
    drive_cell(mk_cell(0, 255, 128, 0, 7, 0, 14, 0));

    set_phase(hbq_pkg::MODE_ASCII, 1'b0, 128, 128, 128);
    drive_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 0));
    drive_cell(mk_cell(255, 255, 255, 0, 255, 255, 255, 0));
    drive_cell(mk_cell(255, 255, 255, 0, 0, 0, 0, 0));
    drive_cell(mk_cell(255, 0, 0, 0, 0, 0, 255, 0));

    set_phase(hbq_pkg::MODE_PALETTE, 1'b1, 255, 255, 255);
    drive_cell(mk_cell(0, 0, 0, 0, 0, 0, 0, 255));

    set_phase(MODE_UNUSED, 1'b0, 128, 128, 128);
    drive_cell(random_cell());
    drive_cell(random_cell());

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 3)
        set_phase(2'(p % 3), 1'b1, 0, 0, 0);
      else if (p == 4)
        set_phase(2'(p % 3), 1'b1, 255, 255, 255);
      else if (p == 7)
        set_phase(MODE_UNUSED, 1'($urandom), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      else
        set_phase(2'(p % 3), 1'(p / 3), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      // long stretch without idling on either side
      tx_gaps = (p != 1);
      rx_gaps = (p != 1);
      @(posedge clk);
      if (p == 2) hold_cycles = 300;
      for (int n = 0; n < PHASE_CELLS; n++)
        drive_cell(random_cell());
    end

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    drain_cells();
    $display("Covered %0d cells and %0d results over %0d register settings, modes seen %b.",
             quant.cells, quant.results, settings, quant.modes_seen);
    if (quant.errors == 0 && quant.pending.size() == 0) begin
      $display("** halfblock_pixel_color_quantizer_unit: PASSED **");
    end else begin
      $display("** halfblock_pixel_color_quantizer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hbq_pkg.sv
rtl/core/hbq_lane.sv
rtl/core/hbq_merge.sv
rtl/core/halfblock_pixel_color_quantizer_unit.sv
tb/testbench.sv
